FILE: hw/rtl/isl_pkg.sv
// Shared types and constants for the indexed shift list.
// Used by the request/response interfaces, the control decoder, the cells and the top level.
package isl_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 4;
  localparam int POS_W         = 7;
  localparam int COUNT_W       = 7;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 64;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 4'd0,
    FN_PUSH_FRONT = 4'd1,
    FN_INSERT     = 4'd2,
    FN_GET        = 4'd3,
    FN_SET        = 4'd4,
    FN_POP_BACK   = 4'd5,
    FN_POP_FRONT  = 4'd6,
    FN_ERASE      = 4'd7,
    FN_CLEAR      = 4'd8
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2,
    CELL_WRITE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    status_t status;
    logic    rd_en;
  } ctrl_rsp_t;

endpackage

FILE: hw/rtl/isl_if.sv
// Request and response channels of the indexed shift list.
// Depends on isl_pkg for field widths.
interface isl_req_if;
  logic                              valid;
  logic                              ready;
  logic [isl_pkg::FUNC_W-1:0]        func;
  logic [isl_pkg::POS_W-1:0]         position;
  logic signed [isl_pkg::DATA_W-1:0] item_value;

  modport source (output valid, func, position, item_value, input ready);
  modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface isl_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [isl_pkg::STATUS_W-1:0]      status;
  logic signed [isl_pkg::DATA_W-1:0] read_value;
  logic [isl_pkg::COUNT_W-1:0]       entry_count;
  logic                              empty_flag;

  modport source (output valid, status, read_value, entry_count, empty_flag, input ready);
  modport sink   (input valid, status, read_value, entry_count, empty_flag, output ready);
endinterface

FILE: hw/rtl/isl_cell.sv
// One entry cell of the list: holds a value, takes from a neighbor on open/close.
// Depends on isl_pkg for the cell command.
module isl_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic                              clk,
  input  isl_pkg::cell_cmd_t                cmd,
  input  logic [PW-1:0]                     pos,
  input  logic signed [isl_pkg::DATA_W-1:0] lower,
  input  logic signed [isl_pkg::DATA_W-1:0] upper,
  output logic signed [isl_pkg::DATA_W-1:0] value
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic signed [isl_pkg::DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.op)
      isl_pkg::CELL_OPEN: begin
        if (MY_IDX > pos) begin
          value_next = lower;
        end else if (MY_IDX == pos) begin
          value_next = cmd.value;
        end
      end
      isl_pkg::CELL_CLOSE: begin
        if (MY_IDX >= pos) begin
          value_next = upper;
        end
      end
      isl_pkg::CELL_WRITE: begin
        if (MY_IDX == pos) begin
          value_next = cmd.value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: hw/rtl/isl_ctrl.sv
// Request decoder: checks the index and count, picks the cell command and next count.
// Depends on isl_pkg for function, status and cell command codes.
module isl_ctrl #(
  parameter int DEPTH = isl_pkg::DEPTH_DEFAULT,
  parameter int CW    = 7,
  parameter int PW    = 7
) (
  input  logic [isl_pkg::FUNC_W-1:0]        func,
  input  logic [isl_pkg::POS_W-1:0]         position,
  input  logic signed [isl_pkg::DATA_W-1:0] item_value,
  input  logic                              accept,
  input  logic [CW-1:0]                     count,
  output isl_pkg::cell_cmd_t                cmd,
  output logic [PW-1:0]                     cell_pos,
  output isl_pkg::ctrl_rsp_t                rsp,
  output logic [CW-1:0]                     count_next
);

  logic [PW-1:0] pos_e;
  logic [PW-1:0] cnt_e;
  logic          full;
  logic          empty;
  isl_pkg::cell_op_t op;

  assign pos_e = PW'(position);
  assign cnt_e = PW'(count);
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    op         = isl_pkg::CELL_HOLD;
    cell_pos   = '0;
    rsp.status = isl_pkg::ST_OK;
    rsp.rd_en  = 1'b0;
    count_next = count;
    case (isl_pkg::func_t'(func))
      isl_pkg::FN_PUSH_BACK: begin
        if (full) begin
          rsp.status = isl_pkg::ST_FULL;
        end else begin
          op         = isl_pkg::CELL_OPEN;
          cell_pos   = cnt_e;
          count_next = count + CW'(1);
        end
      end
      isl_pkg::FN_PUSH_FRONT: begin
        if (full) begin
          rsp.status = isl_pkg::ST_FULL;
        end else begin
          op         = isl_pkg::CELL_OPEN;
          count_next = count + CW'(1);
        end
      end
      isl_pkg::FN_INSERT: begin
        if (pos_e > cnt_e) begin
          rsp.status = isl_pkg::ST_INDEX;
        end else if (full) begin
          rsp.status = isl_pkg::ST_FULL;
        end else begin
          op         = isl_pkg::CELL_OPEN;
          cell_pos   = pos_e;
          count_next = count + CW'(1);
        end
      end
      isl_pkg::FN_GET: begin
        if (pos_e >= cnt_e) begin
          rsp.status = isl_pkg::ST_INDEX;
        end else begin
          rsp.rd_en = 1'b1;
        end
      end
      isl_pkg::FN_SET: begin
        if (pos_e >= cnt_e) begin
          rsp.status = isl_pkg::ST_INDEX;
        end else begin
          op       = isl_pkg::CELL_WRITE;
          cell_pos = pos_e;
        end
      end
      isl_pkg::FN_POP_BACK: begin
        if (empty) begin
          rsp.status = isl_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      isl_pkg::FN_POP_FRONT: begin
        if (empty) begin
          rsp.status = isl_pkg::ST_EMPTY;
        end else begin
          op         = isl_pkg::CELL_CLOSE;
          count_next = count - CW'(1);
        end
      end
      isl_pkg::FN_ERASE: begin
        if (pos_e >= cnt_e) begin
          rsp.status = isl_pkg::ST_INDEX;
        end else begin
          op         = isl_pkg::CELL_CLOSE;
          cell_pos   = pos_e;
          count_next = count - CW'(1);
        end
      end
      isl_pkg::FN_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign cmd.op    = accept ? op : isl_pkg::CELL_HOLD;
  assign cmd.value = item_value;

endmodule

FILE: hw/rtl/indexed_shift_list_unit.sv
// Indexed shift list top level: control decoder, a row of entry cells, response register.
// Depends on isl_pkg, isl_if (isl_req_if, isl_rsp_if), isl_ctrl and isl_cell.
//
//   port | dir | payload
//   req  | in  | func, position, item_value
//   rsp  | out | status, read_value, entry_count, empty_flag
//
// One request per cycle while the response register is free or being taken; its response appears in the
// response register in the cycle after it is accepted. All cells shift in parallel in the accept cycle,
// so insert and erase take no longer than any other request. A stalled response blocks new requests only
// while it is not being taken. Reset clears the count and the response valid; cell contents are not reset.
module indexed_shift_list_unit #(
  parameter int DEPTH = isl_pkg::DEPTH_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  isl_req_if.sink   req,
  isl_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > isl_pkg::POS_W) ? CW : isl_pkg::POS_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                              accept;
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     count_next;
  isl_pkg::cell_cmd_t                cmd;
  logic [PW-1:0]                     cell_pos;
  isl_pkg::ctrl_rsp_t                crsp;
  logic signed [isl_pkg::DATA_W-1:0] cell_q [DEPTH];
  logic [PW-1:0]                     rd_pos;
  logic [AW-1:0]                     rd_idx;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  isl_ctrl #(
    .DEPTH(DEPTH),
    .CW   (CW),
    .PW   (PW)
  ) u_ctrl (
    .func      (req.func),
    .position  (req.position),
    .item_value(req.item_value),
    .accept    (accept),
    .count     (count),
    .cmd       (cmd),
    .cell_pos  (cell_pos),
    .rsp       (crsp),
    .count_next(count_next)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [isl_pkg::DATA_W-1:0] lower;
    logic signed [isl_pkg::DATA_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = cell_q[i];
    end else begin : g_lower
      assign lower = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_q[i];
    end else begin : g_upper
      assign upper = cell_q[i+1];
    end
    isl_cell #(
      .IDX(i),
      .PW (PW)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .pos  (cell_pos),
      .lower(lower),
      .upper(upper),
      .value(cell_q[i])
    );
  end

  assign rd_pos = PW'(req.position);
  assign rd_idx = rd_pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= crsp.status;
      rsp.read_value  <= crsp.rd_en ? cell_q[rd_idx] : '0;
      rsp.entry_count <= isl_pkg::COUNT_W'(count_next);
      rsp.empty_flag  <= (count_next == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted request produced no response");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.empty_flag == (count == '0)))
    else $error("empty flag disagrees with count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == isl_pkg::ST_FULL) |-> (count == CW'(DEPTH)))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == isl_pkg::ST_EMPTY) |-> (count == '0))
    else $error("empty status with entries present");

endmodule
